// File: src/tfn_pkg.sv
// ----------------------------------------------------------------------------
// tfn_pkg
// Shared types and fixed constants of the triangle face normal pipeline.
// ----------------------------------------------------------------------------
package tfn_pkg;

  // Q1.14 output: 16384 is 1.0
  localparam int NORM_BITS  = 16;
  localparam int Q_BITS     = 15;
  localparam int NUM_STEPS  = 15;
  // 2^30 = 16384^2 * 4, scale of the rounding compare
  localparam int SCALE_BITS = 30;
  localparam int COMPS      = 3;

  // sideband that travels with every pipeline stage
  typedef struct packed {
    logic valid;
    logic last;
  } side_t;

endpackage

// File: src/tfn_cross.sv
// ----------------------------------------------------------------------------
// tfn_cross
// Edge vectors and exact cross product, as sign and magnitude. Three stages.
// ----------------------------------------------------------------------------
module tfn_cross #(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  tfn_pkg::side_t               side_in,
  input  logic signed [COORD_BITS-1:0] v0 [3],
  input  logic signed [COORD_BITS-1:0] v1 [3],
  input  logic signed [COORD_BITS-1:0] v2 [3],
  output tfn_pkg::side_t               side_out,
  output logic        [2*COORD_BITS+1:0] mag [3],
  output logic                         sign [3]
);
  import tfn_pkg::*;

  localparam int EW  = COORD_BITS + 1;
  localparam int PRW = 2 * EW;
  localparam int CW  = PRW + 1;
  localparam int MW  = 2 * COORD_BITS + 2;

  side_t                side1, side2;
  logic signed [EW-1:0] u [3];
  logic signed [EW-1:0] w [3];
  logic signed [PRW-1:0] pa [3];
  logic signed [PRW-1:0] pb [3];
  logic signed [CW-1:0]  cr [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      side1    <= '0;
      side2    <= '0;
      side_out <= '0;
    end else begin
      side1    <= side_in;
      side2    <= side1;
      side_out <= side2;
    end
  end

  for (genvar i = 0; i < COMPS; i++) begin : g_edge
    always_ff @(posedge clk) begin
      u[i] <= EW'(v1[i]) - EW'(v0[i]);
      w[i] <= EW'(v2[i]) - EW'(v0[i]);
    end
  end

  // c = (uy*wz - uz*wy, uz*wx - ux*wz, ux*wy - uy*wx)
  always_ff @(posedge clk) begin
    pa[0] <= u[1] * w[2];
    pb[0] <= u[2] * w[1];
    pa[1] <= u[2] * w[0];
    pb[1] <= u[0] * w[2];
    pa[2] <= u[0] * w[1];
    pb[2] <= u[1] * w[0];
  end

  for (genvar i = 0; i < COMPS; i++) begin : g_mag
    assign cr[i] = CW'(pa[i]) - CW'(pb[i]);
    always_ff @(posedge clk) begin
      sign[i] <= cr[i][CW-1];
      mag[i]  <= cr[i][CW-1] ? MW'(-cr[i]) : MW'(cr[i]);
    end
  end

endmodule

// File: src/tfn_square.sv
// ----------------------------------------------------------------------------
// tfn_square
// Squares of the cross product components from half-width partial products,
// and their sum. Three stages.
// ----------------------------------------------------------------------------
module tfn_square #(
  parameter int COORD_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  tfn_pkg::side_t                side_in,
  input  logic [2*COORD_BITS+1:0]       mag [3],
  input  logic                          sign_in [3],
  output tfn_pkg::side_t                side_out,
  output logic [4*COORD_BITS+3:0]       c2 [3],
  output logic [4*COORD_BITS+5:0]       ssum,
  output logic                          sign_out [3]
);
  import tfn_pkg::*;

  localparam int MW  = 2 * COORD_BITS + 2;
  localparam int LOW = MW / 2;
  localparam int HIW = MW - LOW;
  localparam int SQW = 2 * MW;
  localparam int SW  = SQW + 2;

  side_t                 side_a, side_b;
  logic                  sign_a [3];
  logic                  sign_b [3];
  logic [2*HIW-1:0]      hh [3];
  logic [HIW+LOW-1:0]    hl [3];
  logic [2*LOW-1:0]      ll [3];
  logic [SQW-1:0]        sq [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      side_a   <= '0;
      side_b   <= '0;
      side_out <= '0;
    end else begin
      side_a   <= side_in;
      side_b   <= side_a;
      side_out <= side_b;
    end
  end

  for (genvar i = 0; i < COMPS; i++) begin : g_sq
    always_ff @(posedge clk) begin
      hh[i]       <= mag[i][MW-1:LOW] * mag[i][MW-1:LOW];
      hl[i]       <= mag[i][MW-1:LOW] * mag[i][LOW-1:0];
      ll[i]       <= mag[i][LOW-1:0] * mag[i][LOW-1:0];
      sign_a[i]   <= sign_in[i];
      sq[i]       <= (SQW'(hh[i]) << (2 * LOW)) + (SQW'(hl[i]) << (LOW + 1)) + SQW'(ll[i]);
      sign_b[i]   <= sign_a[i];
      c2[i]       <= sq[i];
      sign_out[i] <= sign_b[i];
    end
  end

  always_ff @(posedge clk) begin
    ssum <= SW'(sq[0]) + SW'(sq[1]) + SW'(sq[2]);
  end

endmodule

// File: src/tfn_qstep.sv
// ----------------------------------------------------------------------------
// tfn_qstep
// One bit of the rounded quotient for all three components. Keeps
// P = t^2*s and Q = t*s for t = 2q-1, so a trial bit needs only shifts/adds.
// ----------------------------------------------------------------------------
module tfn_qstep #(
  parameter int COORD_BITS = 16,
  parameter int BIT        = 14
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  tfn_pkg::side_t                        side_in,
  input  logic [4*COORD_BITS+5:0]               ssum_in,
  input  logic [4*COORD_BITS+3:0]               c2_in [3],
  input  logic                                  sign_in [3],
  input  logic [4*COORD_BITS+35:0]              p_in [3],
  input  logic signed [4*COORD_BITS+21:0]       t_in [3],
  input  logic [tfn_pkg::Q_BITS-1:0]            q_in [3],
  output tfn_pkg::side_t                        side_out,
  output logic [4*COORD_BITS+5:0]               ssum_out,
  output logic [4*COORD_BITS+3:0]               c2_out [3],
  output logic                                  sign_out [3],
  output logic [4*COORD_BITS+35:0]              p_out [3],
  output logic signed [4*COORD_BITS+21:0]       t_out [3],
  output logic [tfn_pkg::Q_BITS-1:0]            q_out [3]
);
  import tfn_pkg::*;

  localparam int SQW = 4 * COORD_BITS + 4;
  localparam int SW  = SQW + 2;
  localparam int PW  = SQW + SCALE_BITS + 2;
  localparam int QW  = SW + 16;

  logic [PW-1:0]        s_wide;
  logic signed [QW-1:0] s_sgn;

  assign s_wide = {{(PW-SW){1'b0}}, ssum_in};
  assign s_sgn  = {{(QW-SW){1'b0}}, ssum_in};

  always_ff @(posedge clk) begin
    if (rst) begin
      side_out <= '0;
    end else begin
      side_out <= side_in;
    end
  end

  always_ff @(posedge clk) begin
    ssum_out <= ssum_in;
  end

  for (genvar i = 0; i < COMPS; i++) begin : g_comp
    logic [PW-1:0] q_wide;
    logic [PW-1:0] p_cand;
    logic [PW-1:0] rhs;
    logic          take;

    assign q_wide = {{(PW-QW){t_in[i][QW-1]}}, t_in[i]};
    assign p_cand = p_in[i] + (q_wide << (BIT + 2)) + (s_wide << (2 * BIT + 2));
    assign rhs    = {2'b00, c2_in[i], {SCALE_BITS{1'b0}}};
    // q saturates at 1.0: once bit 14 is set no lower bit may join
    assign take   = !q_in[i][Q_BITS-1] && (p_cand <= rhs);

    always_ff @(posedge clk) begin
      c2_out[i]   <= c2_in[i];
      sign_out[i] <= sign_in[i];
      if (take) begin
        p_out[i] <= p_cand;
        t_out[i] <= t_in[i] + (s_sgn <<< (BIT + 1));
        q_out[i] <= q_in[i] | (Q_BITS'(1) << BIT);
      end else begin
        p_out[i] <= p_in[i];
        t_out[i] <= t_in[i];
        q_out[i] <= q_in[i];
      end
    end
  end

endmodule

// File: src/triangle_face_normal_top.sv
// ----------------------------------------------------------------------------
// triangle_face_normal_top
// Unit face normal of a triangle, signed Q1.14, rounded to nearest.
// ----------------------------------------------------------------------------
//
//  channel  | signals                                   | transfer when
//  ---------+-------------------------------------------+---------------------
//  triangle | start, busy, v0_*/v1_*/v2_*, last_in      | start && !busy
//  normal   | done, normal_*, degenerate, last_out      | done (one cycle)
//
// One triangle per cycle whenever busy is low; from transfer to the done cycle
// it passes 3 stages of cross product, 3 of squaring and summing, 15 quotient bit
// steps (one bit per stage), 1 output register.
// busy is high only during reset; rst is synchronous and empties the pipe.
// The receiver has no backpressure, so nothing in the pipe ever stalls.
// ----------------------------------------------------------------------------
module triangle_face_normal_top #(
  parameter int COORD_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [COORD_BITS-1:0]          v0_x,
  input  logic signed [COORD_BITS-1:0]          v0_y,
  input  logic signed [COORD_BITS-1:0]          v0_z,
  input  logic signed [COORD_BITS-1:0]          v1_x,
  input  logic signed [COORD_BITS-1:0]          v1_y,
  input  logic signed [COORD_BITS-1:0]          v1_z,
  input  logic signed [COORD_BITS-1:0]          v2_x,
  input  logic signed [COORD_BITS-1:0]          v2_y,
  input  logic signed [COORD_BITS-1:0]          v2_z,
  input  logic                                  last_in,
  output logic                                  done,
  output logic signed [tfn_pkg::NORM_BITS-1:0]  normal_x,
  output logic signed [tfn_pkg::NORM_BITS-1:0]  normal_y,
  output logic signed [tfn_pkg::NORM_BITS-1:0]  normal_z,
  output logic                                  degenerate,
  output logic                                  last_out
);
  import tfn_pkg::*;

  localparam int MW      = 2 * COORD_BITS + 2;
  localparam int SQW     = 2 * MW;
  localparam int SW      = SQW + 2;
  localparam int PW      = SQW + SCALE_BITS + 2;
  localparam int QW      = SW + 16;
  localparam int LATENCY = 22;

  side_t                 side_in, side_x, side_s;
  logic signed [COORD_BITS-1:0] v0 [3];
  logic signed [COORD_BITS-1:0] v1 [3];
  logic signed [COORD_BITS-1:0] v2 [3];
  logic [MW-1:0]         mag [3];
  logic                  sign_x [3];

  // quotient chain, index 0 is the seed, NUM_STEPS is the finished value
  side_t                 side_st [NUM_STEPS+1];
  logic [SW-1:0]         ssum_st [NUM_STEPS+1];
  logic [SQW-1:0]        c2_st   [NUM_STEPS+1][3];
  logic                  sign_st [NUM_STEPS+1][3];
  logic [PW-1:0]         p_st    [NUM_STEPS+1][3];
  logic signed [QW-1:0]  t_st    [NUM_STEPS+1][3];
  logic [Q_BITS-1:0]     q_st    [NUM_STEPS+1][3];

  logic signed [NORM_BITS-1:0] nrm [3];
  logic                  deg;

  // reset is the only time the unit refuses a triangle
  assign busy = rst;

  assign side_in.valid = start && !busy;
  assign side_in.last  = last_in;

  assign v0[0] = v0_x;
  assign v0[1] = v0_y;
  assign v0[2] = v0_z;
  assign v1[0] = v1_x;
  assign v1[1] = v1_y;
  assign v1[2] = v1_z;
  assign v2[0] = v2_x;
  assign v2[1] = v2_y;
  assign v2[2] = v2_z;

  tfn_cross #(.COORD_BITS(COORD_BITS)) u_cross (
    .clk      (clk),
    .rst      (rst),
    .side_in  (side_in),
    .v0       (v0),
    .v1       (v1),
    .v2       (v2),
    .side_out (side_x),
    .mag      (mag),
    .sign     (sign_x)
  );

  tfn_square #(.COORD_BITS(COORD_BITS)) u_square (
    .clk      (clk),
    .rst      (rst),
    .side_in  (side_x),
    .mag      (mag),
    .sign_in  (sign_x),
    .side_out (side_s),
    .c2       (c2_st[0]),
    .ssum     (ssum_st[0]),
    .sign_out (sign_st[0])
  );

  // seed: q = 0, t = -1, so P = s and Q = -s
  assign side_st[0] = side_s;
  for (genvar i = 0; i < COMPS; i++) begin : g_seed
    assign p_st[0][i] = {{(PW-SW){1'b0}}, ssum_st[0]};
    assign t_st[0][i] = -$signed({{(QW-SW){1'b0}}, ssum_st[0]});
    assign q_st[0][i] = '0;
  end

  for (genvar k = 0; k < NUM_STEPS; k++) begin : g_step
    tfn_qstep #(.COORD_BITS(COORD_BITS), .BIT(NUM_STEPS - 1 - k)) u_qstep (
      .clk      (clk),
      .rst      (rst),
      .side_in  (side_st[k]),
      .ssum_in  (ssum_st[k]),
      .c2_in    (c2_st[k]),
      .sign_in  (sign_st[k]),
      .p_in     (p_st[k]),
      .t_in     (t_st[k]),
      .q_in     (q_st[k]),
      .side_out (side_st[k+1]),
      .ssum_out (ssum_st[k+1]),
      .c2_out   (c2_st[k+1]),
      .sign_out (sign_st[k+1]),
      .p_out    (p_st[k+1]),
      .t_out    (t_st[k+1]),
      .q_out    (q_st[k+1])
    );
  end

  // zero-length cross product: force zero normal and flag it
  assign deg = (ssum_st[NUM_STEPS] == '0);
  for (genvar i = 0; i < COMPS; i++) begin : g_out
    logic signed [NORM_BITS-1:0] q_ext;
    assign q_ext  = $signed({1'b0, q_st[NUM_STEPS][i]});
    assign nrm[i] = deg ? '0 : (sign_st[NUM_STEPS][i] ? -q_ext : q_ext);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= side_st[NUM_STEPS].valid;
    end
  end

  always_ff @(posedge clk) begin
    normal_x   <= nrm[0];
    normal_y   <= nrm[1];
    normal_z   <= nrm[2];
    degenerate <= deg;
    last_out   <= side_st[NUM_STEPS].last;
  end

  // every transfer in comes out as done once it has passed the whole pipeline
  a_latency : assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("triangle did not emerge after fixed latency");

  a_deg_zero : assert property (@(posedge clk) disable iff (rst)
    (done && degenerate) |-> (normal_x == 0 && normal_y == 0 && normal_z == 0))
    else $error("degenerate result with nonzero normal");

  a_nondeg_nonzero : assert property (@(posedge clk) disable iff (rst)
    (done && !degenerate) |-> (normal_x != 0 || normal_y != 0 || normal_z != 0))
    else $error("non-degenerate result with zero normal");

  a_range : assert property (@(posedge clk) disable iff (rst)
    done |-> (normal_x <= 16384 && normal_x >= -16384 &&
              normal_y <= 16384 && normal_y >= -16384 &&
              normal_z <= 16384 && normal_z >= -16384))
    else $error("normal component beyond unit range");

endmodule
